/* design/fcpa_pkg.sv */
package fcpa_pkg;

    localparam int unsigned SIZE_WIDTH  = 17;
    localparam int unsigned COUNT_WIDTH = 9;
    localparam int unsigned BYTES_WIDTH = 25;
    localparam int unsigned OUT_ADDR_WIDTH = 32;
    localparam int unsigned CFG_DATA_WIDTH = 32;
    localparam int unsigned CFG_INDEX_WIDTH = 2;

    localparam logic [SIZE_WIDTH-1:0]  MIN_CHUNK = 17'd8;
    localparam logic [SIZE_WIDTH-1:0]  MAX_CHUNK = 17'd65536;
    localparam logic [BYTES_WIDTH-1:0] BYTES_MAX = 25'h1FF_FFFF;

    localparam logic [SIZE_WIDTH-1:0]  CHUNK_SIZE_RESET  = 17'd8;
    localparam logic [COUNT_WIDTH-1:0] CHUNK_COUNT_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REFILL = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_EMPTY       = 2'd1,
        STAT_MISMATCH    = 2'd2,
        STAT_NOTHING_USED = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_BASE        = 2'd0,
        CFG_CHUNK_SIZE  = 2'd1,
        CFG_CHUNK_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_FILL
    } state_t;

    typedef struct packed {
        logic    pop_issue;
        logic    pop_done;
        logic    push;
        logic    fill_start;
        logic    fill_step;
        logic    result_load;
        status_t result_status;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic size_match;
        logic stack_empty;
        logic stack_full;
        logic used_zero;
        logic fill_last;
    } dp_stat_t;

endpackage

/* design/fcpa_req_if.sv */
interface fcpa_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       operation;
    logic [fcpa_pkg::SIZE_WIDTH-1:0]  request_size;
    logic [31:0]                      free_address;

    modport source (output valid, operation, request_size, free_address, input ready);
    modport sink (input valid, operation, request_size, free_address, output ready);
endinterface

/* design/fcpa_rsp_if.sv */
interface fcpa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [31:0]                       chunk_address;
    logic [1:0]                        status;
    logic [fcpa_pkg::BYTES_WIDTH-1:0]  used_bytes;
    logic [fcpa_pkg::BYTES_WIDTH-1:0]  peak_bytes;

    modport source (output valid, chunk_address, status, used_bytes, peak_bytes, input ready);
    modport sink (input valid, chunk_address, status, used_bytes, peak_bytes, output ready);
endinterface

/* design/fixed_chunk_pool_allocator_core.sv */
// allocate: result through the stack read register and then the result register
// free, rejected or unknown operation: result in the cycle after accept
// refill: result once the clamped chunk count of stack writes is done, one stack write per cycle
// one item in flight; a new request is taken only in S_IDLE with the result register free or being read
// reset: base 0, chunk size 8, chunk count 256, pool empty, used and peak zero
// stack contents are undefined after reset and need no clearing pass
module fixed_chunk_pool_allocator_core
#(
    parameter int unsigned MAX_CHUNKS = 256,
    parameter int unsigned ADDR_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [fcpa_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [fcpa_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    fcpa_req_if.sink                              req,
    fcpa_rsp_if.source                            rsp
);

    fcpa_pkg::dp_cmd_t  cmd;
    fcpa_pkg::dp_stat_t stat;
    logic               in_ready;

    assign req.ready = in_ready;

    fcpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .operation (req.operation),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    fcpa_dp
    #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .ADDR_WIDTH (ADDR_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .request_size  (req.request_size),
        .free_address  (req.free_address),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .chunk_address (rsp.chunk_address),
        .status        (rsp.status),
        .used_bytes    (rsp.used_bytes),
        .peak_bytes    (rsp.peak_bytes)
    );

endmodule

/* design/fcpa_ctrl.sv */
module fcpa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         operation,
    input  fcpa_pkg::dp_stat_t stat,
    output logic               in_ready,
    output fcpa_pkg::dp_cmd_t  cmd
);

    fcpa_pkg::state_t state_reg;
    fcpa_pkg::state_t state_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.result_status = fcpa_pkg::STAT_OK;
        in_ready = (state_reg == fcpa_pkg::S_IDLE) && stat.out_free;
        accept = in_valid && in_ready;
        unique case (state_reg)
            fcpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (fcpa_pkg::op_t'(operation))
                        fcpa_pkg::OP_ALLOC:
                        begin
                            if (!stat.size_match)
                            begin
                                cmd.result_load = 1'b1;
                                cmd.result_status = fcpa_pkg::STAT_MISMATCH;
                            end
                            else if (stat.stack_empty)
                            begin
                                cmd.result_load = 1'b1;
                                cmd.result_status = fcpa_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_issue = 1'b1;
                                state_next = fcpa_pkg::S_POP;
                            end
                        end
                        fcpa_pkg::OP_FREE:
                        begin
                            cmd.result_load = 1'b1;
                            if (stat.used_zero || stat.stack_full)
                            begin
                                cmd.result_status = fcpa_pkg::STAT_NOTHING_USED;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        fcpa_pkg::OP_REFILL:
                        begin
                            cmd.fill_start = 1'b1;
                            state_next = fcpa_pkg::S_FILL;
                        end
                        default:
                        begin
                            cmd.result_load = 1'b1;
                        end
                    endcase
                end
            end
            fcpa_pkg::S_POP:
            begin
                cmd.pop_done = 1'b1;
                cmd.result_load = 1'b1;
                state_next = fcpa_pkg::S_IDLE;
            end
            fcpa_pkg::S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.result_load = 1'b1;
                    state_next = fcpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fcpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/fcpa_dp.sv */
module fcpa_dp
#(
    parameter int unsigned MAX_CHUNKS = 256,
    parameter int unsigned ADDR_WIDTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [fcpa_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [fcpa_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic [fcpa_pkg::SIZE_WIDTH-1:0]        request_size,
    input  logic [31:0]                            free_address,
    input  fcpa_pkg::dp_cmd_t                      cmd,
    output fcpa_pkg::dp_stat_t                     stat,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [fcpa_pkg::OUT_ADDR_WIDTH-1:0]    chunk_address,
    output logic [1:0]                             status,
    output logic [fcpa_pkg::BYTES_WIDTH-1:0]       used_bytes,
    output logic [fcpa_pkg::BYTES_WIDTH-1:0]       peak_bytes
);

    localparam int unsigned IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
    localparam int unsigned BW = fcpa_pkg::BYTES_WIDTH;
    localparam int unsigned SW = fcpa_pkg::SIZE_WIDTH;

    logic [31:0]                          base_reg;
    logic [SW-1:0]                        chunk_size_reg;
    logic [fcpa_pkg::COUNT_WIDTH-1:0]     chunk_count_reg;

    logic [ADDR_WIDTH-1:0]                stack_mem [MAX_CHUNKS];
    logic [ADDR_WIDTH-1:0]                rd_data_reg;

    logic [CW-1:0]                        count_reg;
    logic [CW-1:0]                        count_next;
    logic [BW-1:0]                        used_reg;
    logic [BW-1:0]                        used_next;
    logic [BW-1:0]                        peak_reg;
    logic [BW-1:0]                        peak_next;
    logic [IW-1:0]                        fill_idx_reg;
    logic [ADDR_WIDTH-1:0]                fill_addr_reg;
    logic                                 out_valid_reg;

    logic [fcpa_pkg::OUT_ADDR_WIDTH-1:0]  out_addr_reg;
    logic [1:0]                           out_status_reg;
    logic [BW-1:0]                        out_used_reg;
    logic [BW-1:0]                        out_peak_reg;

    logic [SW-1:0]                        csz;
    logic [CW-1:0]                        fill_n;
    logic [CW-1:0]                        count_m1;
    logic [BW:0]                          used_sum;

    // effective chunk size and count
    always_comb
    begin
        if (chunk_size_reg < fcpa_pkg::MIN_CHUNK)
        begin
            csz = fcpa_pkg::MIN_CHUNK;
        end
        else if (chunk_size_reg > fcpa_pkg::MAX_CHUNK)
        begin
            csz = fcpa_pkg::MAX_CHUNK;
        end
        else
        begin
            csz = chunk_size_reg;
        end

        if (chunk_count_reg == '0)
        begin
            fill_n = CW'(1);
        end
        else if (32'(chunk_count_reg) > 32'(MAX_CHUNKS))
        begin
            fill_n = CW'(MAX_CHUNKS);
        end
        else
        begin
            fill_n = CW'(chunk_count_reg);
        end
    end

    assign count_m1 = count_reg - CW'(1);
    assign used_sum = {1'b0, used_reg} + (BW + 1)'(csz);

    always_comb
    begin
        stat.out_free    = !out_valid_reg || out_ready;
        stat.size_match  = (request_size == csz);
        stat.stack_empty = (count_reg == '0);
        stat.stack_full  = (count_reg == CW'(MAX_CHUNKS));
        stat.used_zero   = (used_reg == '0);
        stat.fill_last   = (CW'(fill_idx_reg) == fill_n - CW'(1));
    end

    always_comb
    begin
        count_next = count_reg;
        used_next = used_reg;
        peak_next = peak_reg;
        if (cmd.fill_start)
        begin
            count_next = '0;
            used_next = '0;
            peak_next = '0;
        end
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            used_next = (used_reg >= BW'(csz)) ? used_reg - BW'(csz) : '0;
        end
        if (cmd.pop_issue)
        begin
            count_next = count_m1;
        end
        if (cmd.pop_done)
        begin
            used_next = used_sum[BW] ? fcpa_pkg::BYTES_MAX : used_sum[BW-1:0];
            peak_next = (used_next > peak_reg) ? used_next : peak_reg;
        end
        if (cmd.fill_step && stat.fill_last)
        begin
            count_next = fill_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            chunk_size_reg <= fcpa_pkg::CHUNK_SIZE_RESET;
            chunk_count_reg <= fcpa_pkg::CHUNK_COUNT_RESET;
            count_reg <= '0;
            used_reg <= '0;
            peak_reg <= '0;
            fill_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    fcpa_pkg::CFG_BASE:
                    begin
                        base_reg <= cfg_data;
                    end
                    fcpa_pkg::CFG_CHUNK_SIZE:
                    begin
                        chunk_size_reg <= cfg_data[SW-1:0];
                    end
                    fcpa_pkg::CFG_CHUNK_COUNT:
                    begin
                        chunk_count_reg <= cfg_data[fcpa_pkg::COUNT_WIDTH-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            count_reg <= count_next;
            used_reg <= used_next;
            peak_reg <= peak_next;
            if (cmd.fill_start)
            begin
                fill_idx_reg <= '0;
            end
            else if (cmd.fill_step)
            begin
                fill_idx_reg <= fill_idx_reg + IW'(1);
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // free address stack
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[count_reg[IW-1:0]] <= ADDR_WIDTH'(free_address);
        end
        else if (cmd.fill_step)
        begin
            stack_mem[fill_idx_reg] <= fill_addr_reg;
        end
        if (cmd.pop_issue)
        begin
            rd_data_reg <= stack_mem[count_m1[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_start)
        begin
            fill_addr_reg <= ADDR_WIDTH'(base_reg);
        end
        else if (cmd.fill_step)
        begin
            fill_addr_reg <= fill_addr_reg + ADDR_WIDTH'(csz);
        end
        if (cmd.result_load)
        begin
            out_addr_reg <= cmd.pop_done ? fcpa_pkg::OUT_ADDR_WIDTH'(rd_data_reg) : '0;
            out_status_reg <= cmd.result_status;
            out_used_reg <= used_next;
            out_peak_reg <= peak_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign chunk_address = out_addr_reg;
    assign status = out_status_reg;
    assign used_bytes = out_used_reg;
    assign peak_bytes = out_peak_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_CHUNKS))
        else $error("free stack count beyond depth");

    a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= used_reg)
        else $error("peak below used");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> stat.out_free)
        else $error("result register overwritten");

    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_issue |=> cmd.pop_done && cmd.result_load)
        else $error("stack read not completed");

endmodule
